[hw/rtl/epoch_to_calendar_unit_macros.svh]
// ----------------------------------------------------------------------------
// Epoch to calendar unit: assertion macros
// Concurrent check helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_TO_CALENDAR_UNIT_MACROS_SVH

`ifndef SYNTH
`define ECAL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecal check failed");
`define ECAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecal check failed");
`else
`define ECAL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ECAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/ecal_pkg.sv]
// ----------------------------------------------------------------------------
// Epoch to calendar package
// Shared types and constants for the divider and the sequencer.
// ----------------------------------------------------------------------------
package ecal_pkg;

  localparam int unsigned EpochW   = 31;
  localparam int unsigned DivW     = 32;
  localparam int unsigned DivisorW = 6;
  localparam int unsigned ShiftW   = 6;

  // Reciprocals: x / d is (x * magic) >> shift, exact over the ranges used here
  // (below 2^31 for 60, below 2^20 for 24, below 2^15 for 7)
  localparam logic [DivW-1:0]   MagicDiv60 = 32'h8888_8889;
  localparam logic [ShiftW-1:0] ShiftDiv60 = 6'd37;
  localparam logic [DivW-1:0]   MagicDiv24 = 32'hAAAA_AAAB;
  localparam logic [ShiftW-1:0] ShiftDiv24 = 6'd36;
  localparam logic [DivW-1:0]   MagicDiv7  = 32'h2492_4925;
  localparam logic [ShiftW-1:0] ShiftDiv7  = 6'd32;

  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     dividend;
    logic [DivW-1:0]     magic;
    logic [ShiftW-1:0]   shift;
    logic [DivisorW-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic                done;
    logic [DivW-1:0]     quotient;
    logic [DivisorW-1:0] remainder;
  } div_res_t;

  // Month lengths, January first; February has 29 days in a leap year
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd1: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

[hw/rtl/ecal_div.sv]
// ----------------------------------------------------------------------------
// Epoch to calendar: shared constant divider
// Reciprocal multiplication on one shared multiplier: multiply, shift, multiply back, subtract.
// ----------------------------------------------------------------------------
module ecal_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ecal_pkg::div_ctl_t ctl,
  output ecal_pkg::div_res_t res
);
  import ecal_pkg::*;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhMul   = 3'd1;  // dividend times reciprocal
  localparam logic [2:0] PhShift = 3'd2;  // quotient from the high product bits
  localparam logic [2:0] PhBack  = 3'd3;  // quotient times divisor
  localparam logic [2:0] PhSub   = 3'd4;  // remainder

  logic [2:0]          phase_r, phase_nxt;
  logic                done_r;
  logic [DivW-1:0]     num_r;
  logic [DivW-1:0]     magic_r;
  logic [ShiftW-1:0]   shift_r;
  logic [DivisorW-1:0] div_r;
  logic [DivW-1:0]     quo_r;
  logic [DivisorW-1:0] rem_r;
  logic [2*DivW-1:0]   prod_r;
  logic [DivW-1:0]     mul_a, mul_b;

  // One multiplier, shared by the forward and the back multiplication
  assign mul_a = (phase_r == PhMul) ? num_r : quo_r;
  assign mul_b = (phase_r == PhMul) ? magic_r : {{(DivW-DivisorW){1'b0}}, div_r};

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PhIdle:  if (ctl.start) phase_nxt = PhMul;
      PhMul:   phase_nxt = PhShift;
      PhShift: phase_nxt = PhBack;
      PhBack:  phase_nxt = PhSub;
      PhSub:   phase_nxt = PhIdle;
      default: phase_nxt = PhIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhIdle;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == PhSub);
    end
  end

  // Datapath: load on start, then multiply, shift, multiply back, subtract
  always_ff @(posedge clk) begin
    case (phase_r)
      PhIdle: begin
        if (ctl.start) begin
          num_r   <= ctl.dividend;
          magic_r <= ctl.magic;
          shift_r <= ctl.shift;
          div_r   <= ctl.divisor;
        end
      end
      PhMul, PhBack: begin
        prod_r <= (2*DivW)'(mul_a) * (2*DivW)'(mul_b);
      end
      PhShift: begin
        quo_r <= DivW'(prod_r >> shift_r);
      end
      PhSub: begin
        rem_r <= DivisorW'(num_r - prod_r[DivW-1:0]);
      end
      default: begin
      end
    endcase
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

[hw/rtl/epoch_to_calendar_unit.sv]
// ----------------------------------------------------------------------------
// Epoch to calendar unit
// Converts seconds since 1970-01-01 00:00:00 UTC into broken-down UTC time.
// ----------------------------------------------------------------------------
// One item at a time: in_tready is high only while the unit is idle. An item
// makes four passes through the shared divider (seconds, minutes, hours and
// weekday): multiply by a reciprocal, shift out the quotient, multiply it back,
// subtract for the remainder, hand over. The year search then steps one year
// per cycle from 1970 and the month search one month per cycle, and the output
// register is loaded once it is free. The result sits in that register, so a
// finished item waits there without blocking the next acceptance; a second
// result waits in the unit until the first is taken. Leap years use the
// divisible-by-four rule, exact for the 31-bit range.
// ----------------------------------------------------------------------------
module epoch_to_calendar_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] epoch_seconds, [31] zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
  // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month,
  // [45:41] day_of_month, [47:46] zero pad
  output logic [47:0] out_tdata
);
  import ecal_pkg::*;

`include "epoch_to_calendar_unit_macros.svh"

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSec  = 3'd1;
  localparam logic [2:0] StMin  = 3'd2;
  localparam logic [2:0] StHour = 3'd3;
  localparam logic [2:0] StWday = 3'd4;
  localparam logic [2:0] StYear = 3'd5;
  localparam logic [2:0] StMon  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  localparam logic [7:0] FirstYear = 8'd70;   // 1970 as years since 1900
  localparam logic [3:0] LastMonth = 4'd11;

  logic [2:0]  state_r, state_nxt;
  div_ctl_t    div_ctl;
  div_res_t    div_res;

  logic [5:0]  sec_r, min_r;
  logic [4:0]  hour_r;
  logic [2:0]  wday_r;
  logic [14:0] days_r;     // whole days, later the days left to place
  logic [7:0]  year_r;
  logic [8:0]  yday_r;
  logic [3:0]  mon_r;
  logic [47:0] out_data_r;
  logic        out_valid_r;

  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mon_len;
  logic        take_in;
  logic        load_out;

  ecal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .res   (div_res)
  );

  assign in_tready = (state_r == StIdle);
  assign take_in   = in_tvalid && in_tready;
  assign load_out  = (state_r == StOut) && (!out_valid_r || out_tready);

  // Year and month lengths; year mod 4 matches years_since_1900 mod 4
  assign leap     = (year_r[1:0] == 2'b00);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mon_len  = month_len(mon_r, leap);

  // Drive the shared divider: each division starts as the previous one ends
  always_comb begin
    div_ctl = '0;
    case (state_r)
      StIdle: begin
        div_ctl.start    = take_in;
        div_ctl.dividend = {1'b0, in_tdata[30:0]};
        div_ctl.magic    = MagicDiv60;
        div_ctl.shift    = ShiftDiv60;
        div_ctl.divisor  = 6'd60;
      end
      StSec: begin
        // whole minutes, below 2^26
        div_ctl.start    = div_res.done;
        div_ctl.dividend = div_res.quotient;
        div_ctl.magic    = MagicDiv60;
        div_ctl.shift    = ShiftDiv60;
        div_ctl.divisor  = 6'd60;
      end
      StMin: begin
        // whole hours, below 2^20
        div_ctl.start    = div_res.done;
        div_ctl.dividend = div_res.quotient;
        div_ctl.magic    = MagicDiv24;
        div_ctl.shift    = ShiftDiv24;
        div_ctl.divisor  = 6'd24;
      end
      StHour: begin
        // day 0 was a Thursday: offset the day count by four
        div_ctl.start    = div_res.done;
        div_ctl.dividend = {17'd0, 15'(div_res.quotient[14:0] + 15'd4)};
        div_ctl.magic    = MagicDiv7;
        div_ctl.shift    = ShiftDiv7;
        div_ctl.divisor  = 6'd7;
      end
      default: begin
        div_ctl = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      StIdle: if (take_in) state_nxt = StSec;
      StSec:  if (div_res.done) state_nxt = StMin;
      StMin:  if (div_res.done) state_nxt = StHour;
      StHour: if (div_res.done) state_nxt = StWday;
      StWday: if (div_res.done) state_nxt = StYear;
      StYear: if (days_r < {6'd0, year_len}) state_nxt = StMon;
      StMon: begin
        if (mon_r == LastMonth || days_r < {10'd0, mon_len}) state_nxt = StOut;
      end
      StOut:  if (load_out) state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: capture remainders, then step off years and months
  always_ff @(posedge clk) begin
    case (state_r)
      StSec: if (div_res.done) sec_r <= div_res.remainder;
      StMin: if (div_res.done) min_r <= div_res.remainder;
      StHour: begin
        if (div_res.done) begin
          hour_r <= div_res.remainder[4:0];
          days_r <= div_res.quotient[14:0];
        end
      end
      StWday: begin
        if (div_res.done) begin
          wday_r <= div_res.remainder[2:0];
          year_r <= FirstYear;
        end
      end
      StYear: begin
        if (days_r >= {6'd0, year_len}) begin
          days_r <= days_r - {6'd0, year_len};
          year_r <= year_r + 8'd1;
        end else begin
          yday_r <= days_r[8:0];
          mon_r  <= '0;
        end
      end
      StMon: begin
        if (mon_r != LastMonth && days_r >= {10'd0, mon_len}) begin
          days_r <= days_r - {10'd0, mon_len};
          mon_r  <= mon_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the finished item until the sink takes it
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {2'b00, 5'(days_r[4:0] + 5'd1), mon_r, yday_r, year_r,
                     wday_r, hour_r, min_r, sec_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ECAL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, take_in, !in_tready)
  `ECAL_ASSERT_IMPL(a_done_in_div_state, clk, rst_n, div_res.done,
                    (state_r == StSec || state_r == StMin ||
                     state_r == StHour || state_r == StWday))
  `ECAL_ASSERT_IMPL(a_year_in_range, clk, rst_n, state_r == StYear, year_r <= 8'd138)
  `ECAL_ASSERT_IMPL(a_month_days_in_range, clk, rst_n, state_r == StMon,
                    (days_r < 15'd366) && (mon_r <= LastMonth))
  `ECAL_ASSERT_NEXT(a_output_loaded, clk, rst_n, load_out, out_tvalid)

endmodule

[dv/tb_epoch_to_calendar_unit.sv]
// ----------------------------------------------------------------------------
// Epoch to calendar unit testbench
// Drives second counts into the unit over its input stream, takes the
// broken-down UTC time for every accepted item from a hand-written answer or
// an independent calendar calculation, and compares each field of every result in order.
// A short table of calendar edges comes first, then random times, many of them aimed at
// day, month and year boundaries, under random idling on both streams.
// ----------------------------------------------------------------------------
module tb_epoch_to_calendar_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ecal_pkg::*;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned LastDay     = 24854;  // last whole day below 2^31 s
  localparam int unsigned RandomItems = 500;
  localparam int unsigned StallLimit  = 5000;   // cycles with no item moving
  localparam int unsigned HoldOff     = 1200;   // long receiver stall
  localparam int unsigned HoldOffAt   = 60;     // result count that triggers it
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned MaxReports  = 10;

  // Result fields, highest first so that the struct maps onto out_tdata[45:0]
  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [8:0] day_of_year;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_t;

  // One row of the edge table; fixed rows carry a hand-written answer
  typedef struct {
    logic [EpochW-1:0] secs;
    bit                fixed;
    cal_t              want;
  } edge_row_t;

  // What the monitor uses for an accepted item: a fixed answer or none
  typedef struct {
    bit   fixed;
    cal_t want;
  } known_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [30:0] epoch_seconds, [31] zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
  // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month,
  // [45:41] day_of_month, [47:46] zero pad
  logic [47:0] out_tdata;

  known_t    known_q[$];      // one entry per item offered, in offer order
  cal_t      pending_times[$]; // expected times still to come out
  edge_row_t edge_rows[$];
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;

  epoch_to_calendar_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------

  // Every fourth year is a leap year; exact up to 2038
  function automatic int unsigned year_days(input int unsigned yr);
    return (yr % 4 == 0) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(input int unsigned mon, input int unsigned yr);
    case (mon)
      1:          return (yr % 4 == 0) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  // Split the second count, then step whole years and whole months off the day count
  function automatic cal_t to_calendar(input logic [EpochW-1:0] secs);
    cal_t        c;
    int unsigned t, days, yr, rest, mon;
    t = secs;
    c.second = 6'(t % 60);
    t = t / 60;
    c.minute = 6'(t % 60);
    t = t / 60;
    c.hour = 5'(t % 24);
    days = t / 24;
    c.weekday = 3'((days + 4) % 7);   // day zero was a Thursday
    yr = 1970;
    rest = days;
    while (rest >= year_days(yr)) begin
      rest -= year_days(yr);
      yr++;
    end
    c.years_since_1900 = 8'(yr - 1900);
    c.day_of_year = 9'(rest);
    mon = 0;
    while (mon < 11 && rest >= month_days(mon, yr)) begin
      rest -= month_days(mon, yr);
      mon++;
    end
    c.month = 4'(mon);
    c.day_of_month = 5'(rest + 1);
    return c;
  endfunction

  // Day count of the first of a month
  function automatic int unsigned first_of_month(input int unsigned yr, input int unsigned mon);
    int unsigned d;
    d = 0;
    for (int unsigned y = 1970; y < yr; y++) d += year_days(y);
    for (int unsigned m = 0; m < mon; m++) d += month_days(m, yr);
    return d;
  endfunction

  function automatic cal_t cal(input int unsigned sec, input int unsigned min,
                               input int unsigned hr, input int unsigned wday,
                               input int unsigned yr, input int unsigned yday,
                               input int unsigned mon, input int unsigned mday);
    cal_t c;
    c.second = 6'(sec);
    c.minute = 6'(min);
    c.hour = 5'(hr);
    c.weekday = 3'(wday);
    c.years_since_1900 = 8'(yr);
    c.day_of_year = 9'(yday);
    c.month = 4'(mon);
    c.day_of_month = 5'(mday);
    return c;
  endfunction

  function automatic edge_row_t row(input logic [EpochW-1:0] secs, input bit fixed = 1'b0,
                                    input cal_t want = '0);
    edge_row_t r;
    r.secs = secs;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  function automatic string show(input cal_t c);
    return $sformatf("y%0d yday%0d mon%0d mday%0d wday%0d %0d:%0d:%0d",
                     c.years_since_1900, c.day_of_year, c.month, c.day_of_month,
                     c.weekday, c.hour, c.minute, c.second);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one item after an idle gap and hold it until the unit takes it.
  // in_tvalid stays high across a zero gap, so it gets one assignment per step.
  task automatic offer_item(input logic [EpochW-1:0] secs, input bit fixed,
                            input cal_t want, input int unsigned gap);
    known_t k;
    k.fixed = fixed;
    k.want = want;
    known_q.push_back(k);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, secs};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and hold off until every expected time has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_times.size() != 0 || known_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: a random stall per item, one long hold-off so that the
  // unit fills up and stalls its input, and a stretch with no stalls at all
  // --------------------------------------------------------------------------
  initial begin
    int unsigned taken, stall;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == HoldOffAt) stall = HoldOff;
      else if (taken >= 150 && taken < 230) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input acceptance, compare on output acceptance.
  // Both handshakes are sampled at the edge, before any driver update lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    known_t k;
    cal_t   got, want;
    bit     moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        k = known_q.pop_front();
        pending_times.push_back(k.fixed ? k.want : to_calendar(in_tdata[EpochW-1:0]));
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = out_tdata[45:0];
        if (pending_times.size() == 0) begin
          failures++;
          if (failures <= MaxReports) $display("unexpected result: %s", show(got));
        end else begin
          want = pending_times.pop_front();
          if (got.second !== want.second || got.minute !== want.minute ||
              got.hour !== want.hour || got.weekday !== want.weekday ||
              got.years_since_1900 !== want.years_since_1900 ||
              got.day_of_year !== want.day_of_year || got.month !== want.month ||
              got.day_of_month !== want.day_of_month) begin
            failures++;
            if (failures <= MaxReports)
              $display("mismatch: expected %s, got %s", show(want), show(got));
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: end the run when nothing has moved on either stream for too long
  initial begin
    wait (idle_cycles >= StallLimit);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    logic [EpochW-1:0] secs;
    int unsigned       day, sod, yr, mon;

    // Edge table: epoch start, end of the 31-bit range, day, month and year
    // turnovers, February in leap and common years, and alternating bit patterns
    edge_rows.push_back(row(31'd0, 1'b1, cal(0, 0, 0, 4, 70, 0, 0, 1)));
    edge_rows.push_back(row(31'd1));
    edge_rows.push_back(row(31'd59, 1'b1, cal(59, 0, 0, 4, 70, 0, 0, 1)));
    edge_rows.push_back(row(31'd60));
    edge_rows.push_back(row(31'd3599));
    edge_rows.push_back(row(31'd86399, 1'b1, cal(59, 59, 23, 4, 70, 0, 0, 1)));
    edge_rows.push_back(row(31'd86400));
    edge_rows.push_back(row(31'(365 * SecsPerDay - 1)));
    edge_rows.push_back(row(31'(365 * SecsPerDay)));
    edge_rows.push_back(row(31'(423 * SecsPerDay)));       // 1971-02-28
    edge_rows.push_back(row(31'(424 * SecsPerDay)));       // 1971-03-01
    edge_rows.push_back(row(31'(789 * SecsPerDay - 1)));   // 1972-02-28 23:59:59
    edge_rows.push_back(row(31'(789 * SecsPerDay)));       // 1972-02-29
    edge_rows.push_back(row(31'(790 * SecsPerDay)));       // 1972-03-01
    edge_rows.push_back(row(31'(1095 * SecsPerDay)));      // 1972-12-31
    edge_rows.push_back(row(31'(1096 * SecsPerDay)));      // 1973-01-01
    edge_rows.push_back(row(31'd951782400));               // 2000-02-29
    edge_rows.push_back(row(31'h5555_5555));
    edge_rows.push_back(row(31'h2AAA_AAAA));
    edge_rows.push_back(row(31'h3FFF_FFFF));
    edge_rows.push_back(row(31'h4000_0000));
    edge_rows.push_back(row(31'(24855 * SecsPerDay)));     // 2038-01-19 00:00:00
    edge_rows.push_back(row(31'h7FFF_FFFF, 1'b1, cal(7, 14, 3, 2, 138, 18, 0, 19)));

    // Synchronous reset: hold rst_n low, then release it
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (edge_rows[i])
      offer_item(edge_rows[i].secs, edge_rows[i].fixed, edge_rows[i].want,
                 $urandom_range(0, 7));
    drain_results();

    // Random part: a mix of arbitrary times and times on day and month edges
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) drain_results();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          secs = 31'($urandom());
        end
        4, 5, 6: begin
          day = $urandom_range(0, LastDay);
          case ($urandom_range(0, 2))
            0:       sod = 0;
            1:       sod = SecsPerDay - 1;
            default: sod = $urandom_range(0, SecsPerDay - 1);
          endcase
          secs = 31'(day * SecsPerDay + sod);
        end
        default: begin
          // first of a month, or the day before it
          yr = $urandom_range(1970, 2037);
          mon = $urandom_range(0, 11);
          day = first_of_month(yr, mon);
          if (day != 0 && $urandom_range(0, 1) == 1) day--;
          case ($urandom_range(0, 2))
            0:       sod = 0;
            1:       sod = SecsPerDay - 1;
            default: sod = $urandom_range(0, SecsPerDay - 1);
          endcase
          secs = 31'(day * SecsPerDay + sod);
        end
      endcase
      // back-to-back stretch in the middle, random gaps elsewhere
      offer_item(secs, 1'b0, '0, (i >= 200 && i < 260) ? 0 : $urandom_range(0, 7));
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
